@@ sv/spf_pkg.sv @@
// ----------------------------------------------------------------------------
// spf_pkg
// Shared types and constants for the smallest-prime finder.
// ----------------------------------------------------------------------------
`default_nettype none

package spf_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int VALUE_W        = 32;
  localparam int BEST_W         = 31;
  localparam int OUT_TDATA_W    = 40;   // found + smallest_prime, padded to bytes

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_CHECK  = 4'b0010,
    ST_DIVIDE = 4'b0100,
    ST_FINISH = 4'b1000
  } seq_state_t;

  // Status from the remainder unit back to the sequencer
  typedef struct packed {
    logic done;   // one-cycle pulse, remainder valid
    logic zero;   // remainder is zero
  } rem_sts_t;

endpackage

`default_nettype wire

@@ sv/spf_rem.sv @@
// ----------------------------------------------------------------------------
// spf_rem
// Iterative restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module spf_rem
  import spf_pkg::*;
#(
  parameter int NW = DATA_WIDTH_DEF - 1,   // dividend width
  parameter int DW = (NW + 1) / 2 + 1      // divisor width
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output rem_sts_t           sts
);

  localparam int CW = $clog2(NW + 1);

  logic          busy;
  logic          done;
  logic [CW-1:0] cnt;
  logic [NW-1:0] dvd;
  logic [DW-1:0] dsr;
  logic [DW-1:0] rem;
  logic [DW:0]   trial;
  logic [DW:0]   diff;

  assign trial = {rem, dvd[NW-1]};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[NW-2:0], 1'b0};
      // remainder stays below divisor, so the low DW bits hold it
      if (trial >= {1'b0, dsr}) rem <= diff[DW-1:0];
      else                      rem <= trial[DW-1:0];
    end
  end

  assign sts.done = done;
  assign sts.zero = (rem == '0);

endmodule

`default_nettype wire

@@ sv/smallest_prime_finder_core.sv @@
// ----------------------------------------------------------------------------
// smallest_prime_finder_core
// Trial-division primality test over a stream; reports the smallest prime
// of each frame on its last transfer.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_*: one signed element per transfer, s_tlast marks the
//   final element of a frame. Only the low DATA_WIDTH bits of the value are
//   used, sign-extended.
//   Master stream m_*: one result per frame, after the last element.
//   Each element is tested by trial division: divisors d = 2, 3, ... while
//   d*d <= value, the square kept by running increments. Each divisor
//   takes a bounds check, the remainder steps and then a decision on the
//   shared bit-serial remainder unit, one divisor after another. s_tready
//   is high only between elements.
//   The result sits in an output register; the block accepts new elements
//   while it waits. A further last element waits until the previous result
//   has been transferred.
//   Reset clears the running minimum, the found flag and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module smallest_prime_finder_core
  import spf_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [VALUE_W-1:0]     s_tdata,   // [31:0] value
  input  wire logic                   s_tlast,   // last
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_TDATA_W-1:0]      m_tdata    // [0] found, [32:1] smallest_prime
);

  localparam int NW = DATA_WIDTH - 1;           // magnitude bits of a positive value
  localparam int DW = (NW + 1) / 2 + 1;         // divisor width
  localparam int SW = NW + 2;                   // divisor square width

  seq_state_t    state, state_next;
  logic [NW-1:0] n;
  logic [DW-1:0] d;
  logic [SW-1:0] sq;
  logic          last_q;
  logic          prime_q;
  logic [BEST_W-1:0] best_prime;
  logic          seen_prime;
  logic          rem_start;
  rem_sts_t      rem_sts;
  logic          s_xfer;
  logic          in_ok;
  logic          out_free;
  logic          sq_over;
  logic [BEST_W-1:0] cand;

  spf_rem #(.NW(NW), .DW(DW)) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (n),
    .divisor  (d),
    .sts      (rem_sts)
  );

  assign s_tready = (state == ST_IDLE);
  assign s_xfer   = s_tvalid && s_tready;
  // non-negative and at least two
  assign in_ok    = !s_tdata[DATA_WIDTH-1] && (s_tdata[NW-1:0] >= NW'(2));
  assign sq_over  = sq > SW'(n);
  assign rem_start = (state == ST_CHECK) && !sq_over;
  assign out_free = !m_tvalid || m_tready;
  assign cand     = BEST_W'(n);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_xfer) state_next = in_ok ? ST_CHECK : ST_FINISH;
      end
      ST_CHECK: begin
        state_next = sq_over ? ST_FINISH : ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (rem_sts.done) state_next = rem_sts.zero ? ST_FINISH : ST_CHECK;
      end
      ST_FINISH: begin
        if (!last_q || out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      best_prime <= '1;
      seen_prime <= 1'b0;
      m_tvalid   <= 1'b0;
      prime_q    <= 1'b0;
    end else begin
      state <= state_next;
      // a new result loaded in the same cycle keeps valid high
      if (m_tvalid && m_tready && !((state == ST_FINISH) && last_q)) m_tvalid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (s_xfer) prime_q <= 1'b0;
        end
        ST_CHECK: begin
          if (sq_over) prime_q <= 1'b1;
        end
        ST_FINISH: begin
          if (!last_q) begin
            if (prime_q && (!seen_prime || cand < best_prime)) begin
              best_prime <= cand;
              seen_prime <= 1'b1;
            end
          end else if (out_free) begin
            m_tvalid <= 1'b1;
            if (prime_q && (!seen_prime || cand < best_prime)) begin
              m_tdata <= {7'd0, 1'b0, cand, 1'b1};
            end else if (seen_prime) begin
              m_tdata <= {7'd0, 1'b0, best_prime, 1'b1};
            end else begin
              m_tdata <= {7'd0, {VALUE_W{1'b1}}, 1'b0};
            end
            best_prime <= '1;
            seen_prime <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (s_xfer) begin
      n      <= s_tdata[NW-1:0];
      last_q <= s_tlast;
      d      <= DW'(2);
      sq     <= SW'(4);
    end else if ((state == ST_DIVIDE) && rem_sts.done) begin
      // (d+1)^2 = d^2 + 2d + 1
      d  <= d + 1'b1;
      sq <= sq + SW'({d, 1'b1});
    end
  end

endmodule

`default_nettype wire
